FILE: sv/dfr_pkg.sv
// Shared types and constants of the Doppler fractional-delay resampler.
// Used by the front end, the queue, the back end, the top level and the checker.
package dfr_pkg;

   localparam int RING_DEPTH_DEFAULT = 32768;
   localparam int QUEUE_DEPTH = 2;

   localparam int SAMPLE_W = 16;
   localparam int DIST_W = 24;
   localparam int SMOOTH_W = 32;
   localparam int LAG_W = 15;
   localparam int COEFF_W = 16;
   localparam int SPM_W = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 24;

   localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd65521;
   localparam logic [SPM_W-1:0] SPM_RESET = 24'd8426057;

   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING_COEFF = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES_PER_METER = 1'b1;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_GENERATE = 1'b1;

   typedef struct packed {
      logic action;
      logic signed [SAMPLE_W-1:0] sample;
      logic [SMOOTH_W-1:0] distance;
      logic first;
      logic [LAG_W-1:0] lag;
   } dfr_item_type;

endpackage

FILE: sv/doppler_fractional_delay_resampler_core.sv
// Top level of the Doppler fractional-delay resampler.
// Depends on dfr_pkg, dfr_front, dfr_queue and dfr_back.
//
// A write request stores one sample in the ring while the back end is idle; a
// generate request steps the back end through the smoothing multiply, smoothed
// distance update, distance-to-delay multiply, dual ring read, interpolation
// multiplies and response load, the last of which waits until the response register
// is free, and gives one response. The front end register and a two-entry queue
// let requests be taken while the back end is busy or a response waits. The ring is
// a single memory of RING_DEPTH entries, which must be a power of two; a fill count
// stands in for clearing it, so there is no start-up pass after reset.
module doppler_fractional_delay_resampler_core #(
   parameter int RING_DEPTH = dfr_pkg::RING_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_action,
   input  logic signed [dfr_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [dfr_pkg::DIST_W-1:0] req_target_distance,
   input  logic req_block_first,
   input  logic [dfr_pkg::LAG_W-1:0] req_block_lag,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [dfr_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic csr_write_enable,
   input  logic [dfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dfr_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import dfr_pkg::*;

   logic push_valid, push_ready, pop_valid, pop_ready;
   dfr_item_type push_item, pop_item;

   dfr_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_sample_in(req_sample_in),
      .req_target_distance(req_target_distance),
      .req_block_first(req_block_first),
      .req_block_lag(req_block_lag),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item(push_item)
   );

   dfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item(push_item),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item(pop_item)
   );

   dfr_back #(.RING_DEPTH(RING_DEPTH)) u_back (
      .clock(clock),
      .reset(reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item(pop_item),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample_out(rsp_sample_out)
   );

endmodule

FILE: sv/dfr_front.sv
// Front end: takes requests, classifies them and decodes them into queue items.
// Depends on dfr_pkg.
module dfr_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_action,
   input  logic signed [dfr_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [dfr_pkg::DIST_W-1:0] req_target_distance,
   input  logic req_block_first,
   input  logic [dfr_pkg::LAG_W-1:0] req_block_lag,
   output logic push_valid,
   input  logic push_ready,
   output dfr_pkg::dfr_item_type push_item
);
   import dfr_pkg::*;

   logic stage_valid_ff, stage_valid_in;
   dfr_item_type stage_item_ff, stage_item_in;
   logic take;

   assign req_ready = !stage_valid_ff || push_ready;
   assign take = req_valid && req_ready;

   always_comb begin
      stage_item_in = stage_item_ff;
      if (take) begin
         stage_item_in.action = req_action;
         stage_item_in.sample = req_sample_in;
         stage_item_in.lag = req_block_lag;
         if (req_action == ACTION_GENERATE) begin
            stage_item_in.distance = {req_target_distance, 8'd0};
            stage_item_in.first = req_block_first;
         end else begin
            stage_item_in.distance = '0;
            stage_item_in.first = 1'b0;
         end
      end
   end

   assign stage_valid_in = take || (stage_valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_item_ff <= stage_item_in;
   end

   assign push_valid = stage_valid_ff;
   assign push_item = stage_item_ff;

endmodule

FILE: sv/dfr_queue.sv
// Short request queue between the front end and the back end.
// Depends on dfr_pkg.
module dfr_queue #(
   parameter int DEPTH = dfr_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  dfr_pkg::dfr_item_type push_item,
   output logic pop_valid,
   input  logic pop_ready,
   output dfr_pkg::dfr_item_type pop_item
);
   import dfr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dfr_item_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: sv/dfr_back.sv
// Back end: ring memory, distance smoother, delay scaling, interpolation and
// the response register, plus the two configuration registers. Depends on dfr_pkg.
module dfr_back #(
   parameter int RING_DEPTH = dfr_pkg::RING_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   output logic pop_ready,
   input  dfr_pkg::dfr_item_type pop_item,
   input  logic csr_write_enable,
   input  logic [dfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dfr_pkg::CSR_DATA_W-1:0] csr_write_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [dfr_pkg::SAMPLE_W-1:0] rsp_sample_out
);
   import dfr_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCALE = 3'd1;
   localparam logic [2:0] ST_MULT = 3'd2;
   localparam logic [2:0] ST_ADDR = 3'd3;
   localparam logic [2:0] ST_MIX = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [COEFF_W-1:0] coeff_ff, coeff_in;
   logic [SPM_W-1:0] spm_ff, spm_in;
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0] fill_ff, fill_in;
   logic primed_ff, primed_in;
   logic [SMOOTH_W-1:0] sd_ff, sd_in;
   logic signed [50:0] smooth_prod_ff, smooth_prod_in;
   logic [55:0] p_ff, p_in;
   logic [15:0] w_ff, w_in;
   logic signed [33:0] mix_a_ff, mix_a_in, mix_b_ff, mix_b_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;

   logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
   logic signed [SAMPLE_W-1:0] rd1_ff, rd2_ff;
   logic rd1_ok_ff, rd2_ok_ff;
   logic mem_we;
   logic [AW-1:0] mem_wa, ra1, ra2;

   logic [SMOOTH_W-1:0] seed;
   logic [AW+14:0] lag_wide;
   logic [AW+19:0] k_wide;
   logic signed [32:0] diff;
   logic signed [17:0] gain;
   logic signed [35:0] f_sum;
   logic signed [SAMPLE_W-1:0] x1, x2;
   logic signed [17:0] wt1, wt2;
   logic signed [34:0] acc, biased;
   logic out_free;

   assign lag_wide = (AW + 15)'(pop_item.lag);
   assign k_wide = (AW + 20)'(p_ff[55:36]);
   assign ra1 = rp_ff - k_wide[AW-1:0];
   assign ra2 = ra1 - 1'b1;
   assign seed = primed_ff ? sd_ff : pop_item.distance;
   assign diff = $signed({1'b0, pop_item.distance}) - $signed({1'b0, seed});
   assign gain = $signed({1'b0, 17'(17'h10000 - {1'b0, coeff_ff})});
   assign f_sum = $signed({4'd0, sd_ff}) + 36'(smooth_prod_ff >>> 16);
   assign x1 = rd1_ok_ff ? rd1_ff : '0;
   assign x2 = rd2_ok_ff ? rd2_ff : '0;
   assign wt1 = $signed({1'b0, 17'(17'h10000 - {1'b0, w_ff})});
   assign wt2 = $signed({2'b00, w_ff});
   assign acc = mix_a_ff + mix_b_ff;
   assign biased = acc + (acc[34] ? 35'sd65535 : 35'sd0);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == ST_IDLE);
   assign mem_we = (state_ff == ST_IDLE) && pop_valid && (pop_item.action == ACTION_WRITE);
   assign mem_wa = wp_ff + 1'b1;

   always_comb begin
      coeff_in = coeff_ff;
      spm_in = spm_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SMOOTHING_COEFF: coeff_in = csr_write_data[COEFF_W-1:0];
            CSR_SAMPLES_PER_METER: spm_in = csr_write_data[SPM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      wp_in = wp_ff;
      rp_in = rp_ff;
      fill_in = fill_ff;
      primed_in = primed_ff;
      sd_in = sd_ff;
      smooth_prod_in = smooth_prod_ff;
      p_in = p_ff;
      w_in = w_ff;
      mix_a_in = mix_a_ff;
      mix_b_in = mix_b_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               if (pop_item.action == ACTION_WRITE) begin
                  wp_in = mem_wa;
                  if (fill_ff != (AW + 1)'(RING_DEPTH)) begin
                     fill_in = fill_ff + 1'b1;
                  end
               end else begin
                  if (pop_item.first) begin
                     rp_in = wp_ff - lag_wide[AW-1:0];
                  end
                  sd_in = seed;
                  primed_in = 1'b1;
                  smooth_prod_in = diff * gain;
                  state_in = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            sd_in = f_sum[SMOOTH_W-1:0];
            state_in = ST_MULT;
         end
         ST_MULT: begin
            p_in = sd_ff * spm_ff;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            w_in = p_ff[35:20];
            rp_in = rp_ff + 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            mix_a_in = x1 * wt1;
            mix_b_in = x2 * wt2;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_sample_in = biased[31:16];
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         coeff_ff <= COEFF_RESET;
         spm_ff <= SPM_RESET;
         wp_ff <= '0;
         rp_ff <= '0;
         fill_ff <= '0;
         primed_ff <= 1'b0;
         sd_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         coeff_ff <= coeff_in;
         spm_ff <= spm_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         fill_ff <= fill_in;
         primed_ff <= primed_in;
         sd_ff <= sd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smooth_prod_ff <= smooth_prod_in;
      p_ff <= p_in;
      w_ff <= w_in;
      mix_a_ff <= mix_a_in;
      mix_b_ff <= mix_b_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   // Entries are filled in write-pointer order from index one, so the fill count
   // tells which entries have not yet been written; reads of those are taken as zero.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_wa] <= pop_item.sample;
      end
      rd1_ff <= ring_mem[ra1];
      rd2_ff <= ring_mem[ra2];
      rd1_ok_ff <= ((ra1 != '0) && (fill_ff >= {1'b0, ra1}))
                   || (fill_ff == (AW + 1)'(RING_DEPTH));
      rd2_ok_ff <= ((ra2 != '0) && (fill_ff >= {1'b0, ra2}))
                   || (fill_ff == (AW + 1)'(RING_DEPTH));
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

endmodule

FILE: sv/dfr_checker.sv
// Port-level checker for the Doppler fractional-delay resampler, bound to the top level.
// Depends on dfr_pkg and doppler_fractional_delay_resampler_core.
module dfr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_action,
   input logic signed [dfr_pkg::SAMPLE_W-1:0] req_sample_in,
   input logic [dfr_pkg::DIST_W-1:0] req_target_distance,
   input logic req_block_first,
   input logic [dfr_pkg::LAG_W-1:0] req_block_lag,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [dfr_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input logic csr_write_enable,
   input logic [dfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [dfr_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import dfr_pkg::*;

   // Generate requests taken whose response has not yet been taken.
   logic [2:0] pending_ff, pending_in;
   logic gen_take, rsp_take;

   assign gen_take = req_valid && req_ready && (req_action == ACTION_GENERATE);
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (gen_take && !rsp_take) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_take && !gen_take) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_clears_response: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid just after reset");

   a_response_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("stalled response changed or vanished");

   a_no_invented_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without an outstanding generate request");

   a_bounded_backlog: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd5)
      else $error("more generate requests outstanding than the design can hold");

endmodule

bind doppler_fractional_delay_resampler_core dfr_checker u_dfr_checker (.*);
